>>> rtl/ffa_pkg.sv
// Package: sizes, codes and shared types of the first-fit heap allocator.
`default_nettype none
package ffa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int OFFSET_BITS  = 20;

  localparam int SIZE_W    = 21;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS);
  localparam int CMP_W     = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 2;

  localparam int HEAP_LOW   = 64;
  localparam int HEAP_HIGH  = (OFFSET_BITS >= 20) ? 1048576 : (1 << OFFSET_BITS);
  localparam int HEAP_RESET = (65536 < HEAP_HIGH) ? 65536 : HEAP_HIGH;
  localparam int RESET_BYTES0 = HEAP_RESET - HEADER_BYTES;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } cfg_reg_t;

  // One table entry.
  typedef struct packed {
    logic                   valid;
    logic                   used;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] bytes;
  } entry_t;

  // Search record rippling down the chain, one cell per cycle.
  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] bytes;
    logic                   prev_free;
    logic                   next_free;
    logic                   just;
    logic                   last_free;
  } carry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                   init;
    logic [OFFSET_BITS-1:0] init_bytes;
    logic                   clear;
    logic                   commit;
    req_type_t              op;
    logic [SIZE_W-1:0]      size;
    logic [ADDR_W-1:0]      addr;
    logic [ADDR_W-1:0]      base;
    logic                   split;
    logic [OFFSET_BITS-1:0] rem_start;
    logic [OFFSET_BITS-1:0] rem_bytes;
    logic                   prev_free;
    logic                   next_free;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/ffa_if.sv
// Interfaces: request, result and configuration channels.
`default_nettype none
interface ffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ffa_pkg::SIZE_W-1:0]  alloc_size;
  logic [ffa_pkg::ADDR_W-1:0]  free_addr;
  modport source (output valid, req_type, alloc_size, free_addr, input ready);
  modport sink   (input valid, req_type, alloc_size, free_addr, output ready);
endinterface

interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ffa_pkg::ADDR_W-1:0]  payload_addr;
  modport source (output valid, status, payload_addr, input ready);
  modport sink   (input valid, status, payload_addr, output ready);
endinterface

interface ffa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::CFG_IDX_W-1:0] index;
  logic [ffa_pkg::ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/ffa_cell.sv
// One table cell: entry storage, search stage and shift/merge update.
`default_nettype none
module ffa_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head,
  input  ffa_pkg::cmd_t       cmd,
  input  ffa_pkg::carry_t     carry_in,
  output ffa_pkg::carry_t     carry_out,
  input  ffa_pkg::entry_t     left,
  input  wire                 left_first,
  input  ffa_pkg::entry_t     right1,
  input  ffa_pkg::entry_t     right2,
  input  wire                 right_first,
  output ffa_pkg::entry_t     ent,
  output logic                first
);
  import ffa_pkg::*;

  localparam logic [OFFSET_BITS-1:0] HDR = OFFSET_BITS'(HEADER_BYTES);

  entry_t ent_next;
  carry_t carry_next;
  logic   hit;
  logic   is_free;
  logic   after;
  logic [ADDR_W-1:0] payload;

  assign is_free = ent.valid && !ent.used;
  assign payload = cmd.base + ADDR_W'(ent.start) + ADDR_W'(HEADER_BYTES);
  assign hit = (cmd.op == REQ_FREE) ? (ent.valid && ent.used && payload == cmd.addr)
                                    : (is_free && CMP_W'(ent.bytes) >= CMP_W'(cmd.size));
  assign first = hit && !carry_in.found;
  assign after = carry_in.found;

  always_comb begin
    carry_next = carry_in;
    carry_next.just = 1'b0;
    carry_next.last_free = is_free;
    if (first) begin
      carry_next.found     = 1'b1;
      carry_next.start     = ent.start;
      carry_next.bytes     = ent.bytes;
      carry_next.prev_free = carry_in.last_free;
      carry_next.just      = 1'b1;
    end else if (carry_in.just) begin
      carry_next.next_free = is_free;
    end
  end

  always_comb begin
    ent_next = ent;
    if (cmd.op == REQ_ALLOC) begin
      if (first) begin
        ent_next.used = 1'b1;
        if (cmd.split) ent_next.bytes = OFFSET_BITS'(cmd.size);
      end else if (cmd.split && after) begin
        if (left_first) begin
          ent_next = '{valid: 1'b1, used: 1'b0, start: cmd.rem_start, bytes: cmd.rem_bytes};
        end else begin
          ent_next = left;
        end
      end
    end else begin
      unique case ({cmd.prev_free, cmd.next_free})
        2'b00: begin
          if (first) ent_next.used = 1'b0;
        end
        2'b01: begin
          if (first) begin
            ent_next.used  = 1'b0;
            ent_next.bytes = ent.bytes + HDR + right1.bytes;
          end else if (after) begin
            ent_next = right1;
          end
        end
        2'b10: begin
          if (right_first) ent_next.bytes = ent.bytes + HDR + right1.bytes;
          else if (first || after) ent_next = right1;
        end
        default: begin
          if (right_first) ent_next.bytes = ent.bytes + HDR + HDR + right1.bytes + right2.bytes;
          else if (first || after) ent_next = right2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      ent.valid <= head;
      ent.used  <= 1'b0;
      ent.start <= '0;
      ent.bytes <= cmd.init_bytes;
    end else if (cmd.commit) begin
      ent <= ent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator built as a chain of table cells.
//
//   channel  dir  payload                              transfer when
//   req      in   req_type, alloc_size, free_addr      req.valid && req.ready
//   rsp      out  status, payload_addr                 rsp.valid && rsp.ready
//   cfg      in   index (0 heap_base, 1 heap_size), data  cfg.valid && cfg.ready
//
// Flow: a request is scanned as the search record walks the cell chain one cell a
// cycle, then committed; a new request is taken only once the last has left commit.
// Reset is synchronous; the table is valid at once.
// Stalls: a finished result waits in the output register; the next request is
// accepted meanwhile and holds in commit until that register is free.
`default_nettype none
module first_fit_heap_allocator (
  input  wire        clk,
  input  wire        rst,
  ffa_req_if.sink    req,
  ffa_rsp_if.source  rsp,
  ffa_cfg_if.sink    cfg
);
  import ffa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  req_type_t          op;
  logic [SIZE_W-1:0]  size;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  base;

  logic               out_valid;
  status_t            out_status;
  logic [ADDR_W-1:0]  out_addr;

  cmd_t    cmd;
  carry_t  carry [0:MAX_BLOCKS];
  entry_t  ents  [0:MAX_BLOCKS+2];   // cell k sits at k + 1, padding at both ends
  logic    firsts[0:MAX_BLOCKS+2];
  logic [MAX_BLOCKS-1:0] valid_vec;

  carry_t   sum;
  status_t  status_now;
  logic     out_free;
  logic     req_xfer;
  logic     cfg_xfer;
  logic [SIZE_W:0] heap_sat;
  logic [SIZE_W-1:0] cfg_size;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.payload_addr = out_addr;

  // heap_size write saturates into the legal range before the table restarts
  assign cfg_size = cfg.data[SIZE_W-1:0];
  always_comb begin
    heap_sat = {1'b0, cfg_size};
    if (heap_sat < (SIZE_W+1)'(HEAP_LOW))  heap_sat = (SIZE_W+1)'(HEAP_LOW);
    if (heap_sat > (SIZE_W+1)'(HEAP_HIGH)) heap_sat = (SIZE_W+1)'(HEAP_HIGH);
  end

  // search summary at the end of the chain
  assign sum = carry[MAX_BLOCKS];

  always_comb begin
    if (op == REQ_ALLOC) begin
      if (size == '0)      status_now = ST_ZERO;
      else if (!sum.found) status_now = ST_NOFIT;
      else                 status_now = ST_OK;
    end else begin
      if (addr == '0)      status_now = ST_ZERO;
      else if (!sum.found) status_now = ST_UNKNOWN;
      else                 status_now = ST_OK;
    end
  end

  always_comb begin
    cmd.init       = cfg_xfer && (cfg.index == REG_HEAP_SIZE);
    cmd.init_bytes = rst ? OFFSET_BITS'(RESET_BYTES0)
                         : OFFSET_BITS'(heap_sat - (SIZE_W+1)'(HEADER_BYTES));
    cmd.clear      = req_xfer;
    cmd.commit     = (state == S_COMMIT) && out_free && (status_now == ST_OK);
    cmd.op         = op;
    cmd.size       = size;
    cmd.addr       = addr;
    cmd.base       = base;
    // split only when the remainder holds a header plus a byte and a cell is spare
    cmd.split      = (op == REQ_ALLOC)
                     && (CMP_W'(sum.bytes) > CMP_W'(HEADER_BYTES) + CMP_W'(size))
                     && !valid_vec[MAX_BLOCKS-1];
    cmd.rem_start  = sum.start + OFFSET_BITS'(HEADER_BYTES) + OFFSET_BITS'(size);
    cmd.rem_bytes  = sum.bytes - OFFSET_BITS'(HEADER_BYTES) - OFFSET_BITS'(size);
    cmd.prev_free  = sum.prev_free;
    cmd.next_free  = sum.next_free;
  end

  assign carry[0]              = '0;
  assign ents[0]               = '0;
  assign ents[MAX_BLOCKS+1]    = '0;
  assign ents[MAX_BLOCKS+2]    = '0;
  assign firsts[0]             = 1'b0;
  assign firsts[MAX_BLOCKS+1]  = 1'b0;
  assign firsts[MAX_BLOCKS+2]  = 1'b0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffa_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .head        (k == 0),
      .cmd         (cmd),
      .carry_in    (carry[k]),
      .carry_out   (carry[k+1]),
      .left        (ents[k]),
      .left_first  (firsts[k]),
      .right1      (ents[k+2]),
      .right2      (ents[k+3]),
      .right_first (firsts[k+2]),
      .ent         (ents[k+1]),
      .first       (firsts[k+1])
    );
    assign valid_vec[k] = ents[k+1].valid;
  end

  // request sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      base      <= '0;
    end else begin
      if (cfg_xfer && cfg.index == REG_HEAP_BASE) base <= cfg.data;
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            op    <= req_type_t'(req.req_type);
            size  <= req.alloc_size;
            addr  <= req.free_addr;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_BLOCKS - 1)) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= status_now;
            out_addr   <= (op == REQ_ALLOC && status_now == ST_OK)
                          ? base + ADDR_W'(sum.start) + ADDR_W'(HEADER_BYTES) : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // live entries stay packed at the front of the chain
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0 && valid_vec[0])
    else $error("table entries not packed");

  // the first block always starts at the heap base
  a_head_start: assert property (@(posedge clk) disable iff (rst)
    ents[1].start == '0)
    else $error("first block offset not zero");

  // a result is only produced from the commit step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_COMMIT))
    else $error("result raised outside commit");

  // the table only changes on a commit or a heap_size write; checked on the valid flags during a scan
  a_table_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !cmd.init) |=> $stable(valid_vec))
    else $error("table changed during scan");
`endif

endmodule
`default_nettype wire
